[rtl/scfr_pkg.sv]
// shared types and constants of the serial command frame responder
package scfr_pkg;

	localparam logic [7:0] HDR_BYTE        = 8'hFF;
	localparam logic [7:0] CHECK_MASK      = 8'hFE;
	localparam logic [7:0] REPLY_OFFSET    = 8'h40;
	localparam logic [7:0] THRESHOLD_RESET = 8'd250;
	localparam logic [7:0] MIN_SIZE        = 8'd7;

	// request command codes
	localparam logic [7:0] CMD_ALL       = 8'h00;
	localparam logic [7:0] CMD_RED       = 8'h01;
	localparam logic [7:0] CMD_GREEN     = 8'h02;
	localparam logic [7:0] CMD_BLUE      = 8'h03;
	localparam logic [7:0] CMD_PROX      = 8'h04;
	localparam logic [7:0] CMD_COLOR     = 8'h05;
	localparam logic [7:0] CMD_SET_LED   = 8'h08;
	localparam logic [7:0] CMD_SET_THRES = 8'h09;

	// input item kinds
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// color classes
	localparam logic [1:0] COLOR_NONE  = 2'd0;
	localparam logic [1:0] COLOR_RED   = 2'd1;
	localparam logic [1:0] COLOR_OTHER = 2'd2;

	// byte positions of a reply frame
	localparam logic [3:0] POS_HDR1  = 4'd0;
	localparam logic [3:0] POS_HDR2  = 4'd1;
	localparam logic [3:0] POS_SIZE  = 4'd2;
	localparam logic [3:0] POS_ID    = 4'd3;
	localparam logic [3:0] POS_CMD   = 4'd4;
	localparam logic [3:0] POS_CHK1  = 4'd5;
	localparam logic [3:0] POS_CHK2  = 4'd6;
	localparam logic [3:0] POS_DATA0 = 4'd7;
	localparam logic [3:0] POS_DATA1 = 4'd8;
	localparam logic [3:0] POS_DATA2 = 4'd9;
	localparam logic [3:0] POS_DATA3 = 4'd10;
	localparam logic [3:0] POS_DATA4 = 4'd11;

	typedef enum logic [3:0] {
		PS_IDLE = 4'd0,
		PS_HDR2 = 4'd1,
		PS_SIZE = 4'd2,
		PS_ID   = 4'd3,
		PS_CMD  = 4'd4,
		PS_CHK1 = 4'd5,
		PS_CHK2 = 4'd6,
		PS_DATA = 4'd7
	} parse_state_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  rx_byte;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [7:0]  proximity;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} out_item_t;

	// stored sensor sample as seen by the reply builder
	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [7:0]  proximity;
		logic [1:0]  color;
	} sample_t;

	// checked frame handed from the parser to the reply builder
	typedef struct packed {
		logic       load;
		logic [7:0] cmd;
	} reply_req_t;

endpackage

[rtl/scfr_reply.sv]
// reply frame builder and byte streamer
module scfr_reply (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scfr_pkg::reply_req_t  req,
	input  scfr_pkg::sample_t     sample,
	input  logic [7:0]            device_id,
	output logic                  busy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output scfr_pkg::out_item_t   out_item
);

	logic       busy_q;
	logic [3:0] idx_q;
	logic [3:0] last_idx_q;
	logic [7:0] cmd_q;
	logic [7:0] chk_q;
	logic [7:0] data_q [0:4];

	logic       known;
	logic [3:0] len;
	logic [7:0] data_d [0:4];
	logic [7:0] reply_cmd;
	logic [7:0] sum;
	logic       out_acc;
	logic [7:0] byte_mux;

	// reply layout per request command
	always_comb begin
		known = 1'b1;
		len   = 4'd7;
		for (int i = 0; i < 5; i++) begin
			data_d[i] = 8'h00;
		end
		unique case (req.cmd)
			scfr_pkg::CMD_ALL: begin
				len       = 4'd12;
				data_d[0] = sample.red[15:8];
				data_d[1] = sample.red[7:0];
				data_d[2] = sample.green[15:8];
				data_d[3] = sample.green[7:0];
				data_d[4] = sample.proximity;
			end
			scfr_pkg::CMD_RED: begin
				len       = 4'd9;
				data_d[0] = sample.red[15:8];
				data_d[1] = sample.red[7:0];
			end
			scfr_pkg::CMD_GREEN: begin
				len       = 4'd9;
				data_d[0] = sample.green[15:8];
				data_d[1] = sample.green[7:0];
			end
			scfr_pkg::CMD_BLUE: begin
				len       = 4'd9;
				data_d[0] = sample.blue[15:8];
				data_d[1] = sample.blue[7:0];
			end
			scfr_pkg::CMD_PROX: begin
				len       = 4'd8;
				data_d[0] = sample.proximity;
			end
			scfr_pkg::CMD_COLOR: begin
				len       = 4'd8;
				data_d[0] = {6'd0, sample.color};
			end
			scfr_pkg::CMD_SET_LED,
			scfr_pkg::CMD_SET_THRES: begin
				len = 4'd7;
			end
			default: begin
				known = 1'b0;
			end
		endcase
		reply_cmd = req.cmd + scfr_pkg::REPLY_OFFSET;
		// two header bytes add up to 0xFE, unused data bytes are zero
		sum = scfr_pkg::HDR_BYTE + scfr_pkg::HDR_BYTE + {4'd0, len} + device_id
			+ reply_cmd + data_d[0] + data_d[1] + data_d[2] + data_d[3] + data_d[4];
	end

	assign out_acc = busy_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= 4'd0;
			last_idx_q <= 4'd0;
		end else begin
			if (req.load && known) begin
				busy_q     <= 1'b1;
				idx_q      <= scfr_pkg::POS_HDR1;
				last_idx_q <= len - 4'd1;
			end else if (out_acc) begin
				if (idx_q == last_idx_q) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load && known) begin
			cmd_q <= reply_cmd;
			chk_q <= sum & scfr_pkg::CHECK_MASK;
			for (int i = 0; i < 5; i++) begin
				data_q[i] <= data_d[i];
			end
		end
	end

	always_comb begin
		unique case (idx_q)
			scfr_pkg::POS_HDR1:  byte_mux = scfr_pkg::HDR_BYTE;
			scfr_pkg::POS_HDR2:  byte_mux = scfr_pkg::HDR_BYTE;
			scfr_pkg::POS_SIZE:  byte_mux = {4'd0, last_idx_q} + 8'd1;
			scfr_pkg::POS_ID:    byte_mux = device_id;
			scfr_pkg::POS_CMD:   byte_mux = cmd_q;
			scfr_pkg::POS_CHK1:  byte_mux = chk_q;
			scfr_pkg::POS_CHK2:  byte_mux = ~chk_q & scfr_pkg::CHECK_MASK;
			scfr_pkg::POS_DATA0: byte_mux = data_q[0];
			scfr_pkg::POS_DATA1: byte_mux = data_q[1];
			scfr_pkg::POS_DATA2: byte_mux = data_q[2];
			scfr_pkg::POS_DATA3: byte_mux = data_q[3];
			scfr_pkg::POS_DATA4: byte_mux = data_q[4];
			default:             byte_mux = 8'h00;
		endcase
	end

	assign busy               = busy_q;
	assign out_valid          = busy_q;
	assign out_item.tx_byte   = byte_mux;
	assign out_item.last_byte = (idx_q == last_idx_q);

`ifndef NO_ASSERTIONS
	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.load && busy_q))
		else $error("reply requested while a reply is still streaming");

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= last_idx_q && last_idx_q >= 4'd6 && last_idx_q <= 4'd11))
		else $error("reply byte index outside the frame");

	a_keep_streaming: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && idx_q != last_idx_q) |=> (busy_q && idx_q == $past(idx_q) + 4'd1))
		else $error("reply stopped before its last byte");
`endif

endmodule

[rtl/serial_command_frame_responder.sv]
// top level of the serial command frame responder with color sensor front end
//
// usage
//  - in channel (in_valid/in_ready/in_item): each item is either a received
//    serial byte (command 0) or a new sensor sample (command 1)
//  - out channel (out_valid/out_ready/out_item): reply frames, one byte per item,
//    last_byte marks the final byte of a frame (7 to 12 bytes per frame)
//  - cfg channel (cfg_valid/cfg_ready/cfg_data): writes device_id, always ready;
//    write only while no reply is pending
// timing
//  - every input item is consumed in the cycle it is accepted; one item per cycle while in_ready is high
//  - a frame that checks out and carries a known command raises out_valid the
//    cycle after its last byte, then one reply byte per cycle while out_ready is high
//  - in_ready stays high while no reply streams; it only drops when a reply is
//    still streaming and the parser sits on a byte that could close a frame,
//    since the single reply buffer holds one frame
// reset
//  - arst_n clears the parser, the stored sample and device_id, and loads the
//    proximity threshold with 250; no reply is pending after reset
// stalls
//  - a low out_ready just holds the current reply byte
module serial_command_frame_responder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  scfr_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output scfr_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_data
);

	// configuration
	logic [7:0] device_id_q;

	// parser state
	scfr_pkg::parse_state_t state_q, state_d;
	logic [7:0] running_sum_q;
	logic [7:0] frame_size_q;
	logic [7:0] frame_command_q;
	logic [7:0] received_check_one_q;
	logic [7:0] received_check_two_q;

	// stored sample and threshold
	logic [15:0] red_q;
	logic [15:0] green_q;
	logic [15:0] blue_q;
	logic [7:0]  proximity_q;
	logic [1:0]  color_q;
	logic [7:0]  threshold_q;

	logic       in_acc;
	logic       byte_acc;
	logic       sample_acc;
	logic [7:0] rx;
	logic [7:0] sum_add;
	logic [7:0] chk_sum;
	logic [7:0] exp_c1;
	logic [7:0] exp_c2;
	logic [7:0] got_c2;
	logic [7:0] data_byte;
	logic       frame_done;
	logic       frame_ok;
	logic [1:0] color_d;
	logic       reply_busy;

	scfr_pkg::reply_req_t req;
	scfr_pkg::sample_t    sample;

	// while a reply streams, input waits in the states where a byte can close a frame
	assign in_ready   = !(reply_busy &&
		(state_q == scfr_pkg::PS_CHK2 || state_q == scfr_pkg::PS_DATA));
	assign in_acc     = in_valid && in_ready;
	assign byte_acc   = in_acc && (in_item.command == scfr_pkg::KIND_BYTE);
	assign sample_acc = in_acc && (in_item.command == scfr_pkg::KIND_SAMPLE);
	assign rx         = in_item.rx_byte;
	assign sum_add    = running_sum_q + rx;

	assign cfg_ready = 1'b1;

	// next parse state
	always_comb begin
		state_d = state_q;
		if (byte_acc) begin
			unique case (state_q)
				scfr_pkg::PS_HDR2:
					state_d = (rx == scfr_pkg::HDR_BYTE) ? scfr_pkg::PS_SIZE : scfr_pkg::PS_IDLE;
				scfr_pkg::PS_SIZE:
					state_d = (rx < scfr_pkg::MIN_SIZE) ? scfr_pkg::PS_IDLE : scfr_pkg::PS_ID;
				scfr_pkg::PS_ID:
					state_d = (rx == device_id_q) ? scfr_pkg::PS_CMD : scfr_pkg::PS_IDLE;
				scfr_pkg::PS_CMD:
					state_d = scfr_pkg::PS_CHK1;
				scfr_pkg::PS_CHK1:
					state_d = scfr_pkg::PS_CHK2;
				scfr_pkg::PS_CHK2:
					state_d = (frame_size_q > scfr_pkg::MIN_SIZE) ? scfr_pkg::PS_DATA
						: scfr_pkg::PS_IDLE;
				scfr_pkg::PS_DATA:
					state_d = scfr_pkg::PS_IDLE;
				default:
					state_d = (rx == scfr_pkg::HDR_BYTE) ? scfr_pkg::PS_HDR2 : scfr_pkg::PS_IDLE;
			endcase
		end
	end

	// frame check at the closing byte
	always_comb begin
		chk_sum    = (state_q == scfr_pkg::PS_DATA) ? sum_add : running_sum_q;
		exp_c1     = chk_sum & scfr_pkg::CHECK_MASK;
		exp_c2     = ~exp_c1 & scfr_pkg::CHECK_MASK;
		got_c2     = (state_q == scfr_pkg::PS_CHK2) ? rx : received_check_two_q;
		data_byte  = (state_q == scfr_pkg::PS_DATA) ? rx : 8'h00;
		frame_done = byte_acc && ((state_q == scfr_pkg::PS_DATA) ||
			(state_q == scfr_pkg::PS_CHK2 && frame_size_q <= scfr_pkg::MIN_SIZE));
		frame_ok   = frame_done && (received_check_one_q == exp_c1) && (got_c2 == exp_c2);
		req.load   = frame_ok;
		req.cmd    = frame_command_q;
	end

	// color class of an incoming sample
	always_comb begin
		priority if (in_item.proximity < threshold_q) begin
			color_d = scfr_pkg::COLOR_NONE;
		end else if (in_item.red > in_item.green) begin
			color_d = scfr_pkg::COLOR_RED;
		end else begin
			color_d = scfr_pkg::COLOR_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q          <= 8'h00;
			state_q              <= scfr_pkg::PS_IDLE;
			running_sum_q        <= 8'h00;
			frame_size_q         <= 8'h00;
			frame_command_q      <= 8'h00;
			received_check_one_q <= 8'h00;
			received_check_two_q <= 8'h00;
			red_q                <= 16'h0000;
			green_q              <= 16'h0000;
			blue_q               <= 16'h0000;
			proximity_q          <= 8'h00;
			color_q              <= scfr_pkg::COLOR_NONE;
			threshold_q          <= scfr_pkg::THRESHOLD_RESET;
		end else begin
			if (cfg_valid) begin
				device_id_q <= cfg_data;
			end
			state_q <= state_d;
			if (byte_acc) begin
				unique case (state_q)
					scfr_pkg::PS_HDR2,
					scfr_pkg::PS_ID:   running_sum_q <= sum_add;
					scfr_pkg::PS_SIZE: begin
						running_sum_q <= sum_add;
						frame_size_q  <= rx;
					end
					scfr_pkg::PS_CMD: begin
						running_sum_q   <= sum_add;
						frame_command_q <= rx;
					end
					scfr_pkg::PS_CHK1: received_check_one_q <= rx;
					scfr_pkg::PS_CHK2: received_check_two_q <= rx;
					scfr_pkg::PS_DATA: running_sum_q        <= sum_add;
					// waiting for a header: the sum restarts at this byte
					default:           running_sum_q        <= rx;
				endcase
			end
			// threshold write takes effect from the next sample on
			if (frame_ok && frame_command_q == scfr_pkg::CMD_SET_THRES) begin
				threshold_q <= data_byte;
			end
			if (sample_acc) begin
				red_q       <= in_item.red;
				green_q     <= in_item.green;
				blue_q      <= in_item.blue;
				proximity_q <= in_item.proximity;
				color_q     <= color_d;
			end
		end
	end

	assign sample.red       = red_q;
	assign sample.green     = green_q;
	assign sample.blue      = blue_q;
	assign sample.proximity = proximity_q;
	assign sample.color     = color_q;

	// reply buffer and byte streamer
	scfr_reply u_reply (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.sample    (sample),
		.device_id (device_id_q),
		.busy      (reply_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

`ifndef NO_ASSERTIONS
	a_done_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> (state_q == scfr_pkg::PS_IDLE))
		else $error("parser did not restart after a closing byte");

	a_sample_keeps_parser: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc |=> (state_q == $past(state_q)))
		else $error("sensor sample moved the frame parser");

	a_reply_follows_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_ok && (frame_command_q == scfr_pkg::CMD_SET_LED ||
			frame_command_q == scfr_pkg::CMD_SET_THRES)) |=> out_valid)
		else $error("checked setup frame gave no acknowledge");
`endif

endmodule

[verif/scfr_reply_checker.sv]
// scoreboard that predicts and checks the reply bytes of the frame responder
module scfr_reply_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  scfr_pkg::in_item_t   in_item,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  scfr_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [7:0]           cfg_data,
	output int                   fails,
	output int                   pending,
	output int                   replies
);

	// predicted copy of the block state
	logic [7:0]             dev_id;
	scfr_pkg::parse_state_t pstate;
	logic [7:0]             sum_acc;
	logic [7:0]             fsize;
	logic [7:0]             fcmd;
	logic [7:0]             fdata;
	logic [7:0]             chk1_rx;
	logic [7:0]             chk2_rx;
	logic [7:0]             thresh;
	scfr_pkg::sample_t      reading;
	scfr_pkg::out_item_t    reply_bytes[$];
	int                     mismatches;

	task automatic queue_reply();
		logic [7:0] msg [12];
		int         n;
		logic [7:0] s;
		for (int j = 0; j < 12; j++)
			msg[j] = 8'h00;
		n = 0;
		case (fcmd)
			scfr_pkg::CMD_ALL: begin
				msg[scfr_pkg::POS_DATA0] = reading.red[15:8];
				msg[scfr_pkg::POS_DATA1] = reading.red[7:0];
				msg[scfr_pkg::POS_DATA2] = reading.green[15:8];
				msg[scfr_pkg::POS_DATA3] = reading.green[7:0];
				msg[scfr_pkg::POS_DATA4] = reading.proximity;
				n = 12;
			end
			scfr_pkg::CMD_RED: begin
				msg[scfr_pkg::POS_DATA0] = reading.red[15:8];
				msg[scfr_pkg::POS_DATA1] = reading.red[7:0];
				n = 9;
			end
			scfr_pkg::CMD_GREEN: begin
				msg[scfr_pkg::POS_DATA0] = reading.green[15:8];
				msg[scfr_pkg::POS_DATA1] = reading.green[7:0];
				n = 9;
			end
			scfr_pkg::CMD_BLUE: begin
				msg[scfr_pkg::POS_DATA0] = reading.blue[15:8];
				msg[scfr_pkg::POS_DATA1] = reading.blue[7:0];
				n = 9;
			end
			scfr_pkg::CMD_PROX: begin
				msg[scfr_pkg::POS_DATA0] = reading.proximity;
				n = 8;
			end
			scfr_pkg::CMD_COLOR: begin
				msg[scfr_pkg::POS_DATA0] = {6'd0, reading.color};
				n = 8;
			end
			scfr_pkg::CMD_SET_LED: begin
				n = 7;
			end
			scfr_pkg::CMD_SET_THRES: begin
				thresh = fdata;
				n = 7;
			end
			default: begin
				n = 0;
			end
		endcase
		if (n != 0) begin
			msg[scfr_pkg::POS_HDR1] = scfr_pkg::HDR_BYTE;
			msg[scfr_pkg::POS_HDR2] = scfr_pkg::HDR_BYTE;
			msg[scfr_pkg::POS_SIZE] = n[7:0];
			msg[scfr_pkg::POS_ID]   = dev_id;
			msg[scfr_pkg::POS_CMD]  = fcmd + scfr_pkg::REPLY_OFFSET;
			s = 8'h00;
			for (int j = 0; j < n; j++)
				if (j != scfr_pkg::POS_CHK1 && j != scfr_pkg::POS_CHK2)
					s = s + msg[j];
			msg[scfr_pkg::POS_CHK1] = s & scfr_pkg::CHECK_MASK;
			msg[scfr_pkg::POS_CHK2] = ~msg[scfr_pkg::POS_CHK1] & scfr_pkg::CHECK_MASK;
			for (int j = 0; j < n; j++)
				reply_bytes.push_back('{tx_byte: msg[j], last_byte: (j == n - 1)});
			replies++;
		end
	endtask

	task automatic close_frame();
		logic [7:0] c1;
		c1 = sum_acc & scfr_pkg::CHECK_MASK;
		pstate = scfr_pkg::PS_IDLE;
		if (chk1_rx == c1 && chk2_rx == (~c1 & scfr_pkg::CHECK_MASK))
			queue_reply();
	endtask

	task automatic take_byte(input logic [7:0] c);
		case (pstate)
			scfr_pkg::PS_HDR2: begin
				sum_acc = sum_acc + c;
				pstate = (c == scfr_pkg::HDR_BYTE) ? scfr_pkg::PS_SIZE : scfr_pkg::PS_IDLE;
			end
			scfr_pkg::PS_SIZE: begin
				sum_acc = sum_acc + c;
				fsize = c;
				pstate = (c < scfr_pkg::MIN_SIZE) ? scfr_pkg::PS_IDLE : scfr_pkg::PS_ID;
			end
			scfr_pkg::PS_ID: begin
				sum_acc = sum_acc + c;
				pstate = (c == dev_id) ? scfr_pkg::PS_CMD : scfr_pkg::PS_IDLE;
			end
			scfr_pkg::PS_CMD: begin
				sum_acc = sum_acc + c;
				fcmd = c;
				pstate = scfr_pkg::PS_CHK1;
			end
			scfr_pkg::PS_CHK1: begin
				chk1_rx = c;
				pstate = scfr_pkg::PS_CHK2;
			end
			scfr_pkg::PS_CHK2: begin
				chk2_rx = c;
				if (fsize > scfr_pkg::MIN_SIZE) begin
					pstate = scfr_pkg::PS_DATA;
				end else begin
					fdata = 8'h00;
					close_frame();
				end
			end
			scfr_pkg::PS_DATA: begin
				sum_acc = sum_acc + c;
				fdata = c;
				close_frame();
			end
			default: begin
				sum_acc = c;
				pstate = (c == scfr_pkg::HDR_BYTE) ? scfr_pkg::PS_HDR2 : scfr_pkg::PS_IDLE;
			end
		endcase
	endtask

	task automatic take_reading(input scfr_pkg::in_item_t it);
		reading.red       = it.red;
		reading.green     = it.green;
		reading.blue      = it.blue;
		reading.proximity = it.proximity;
		if (it.proximity < thresh)
			reading.color = scfr_pkg::COLOR_NONE;
		else if (it.red > it.green)
			reading.color = scfr_pkg::COLOR_RED;
		else
			reading.color = scfr_pkg::COLOR_OTHER;
	endtask

	always @(posedge clk or negedge arst_n) begin
		scfr_pkg::out_item_t want;
		if (!arst_n) begin
			dev_id     = 8'h00;
			pstate     = scfr_pkg::PS_IDLE;
			sum_acc    = 8'h00;
			fsize      = 8'h00;
			fcmd       = 8'h00;
			fdata      = 8'h00;
			chk1_rx    = 8'h00;
			chk2_rx    = 8'h00;
			thresh     = scfr_pkg::THRESHOLD_RESET;
			reading    = '0;
			reply_bytes.delete();
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				dev_id = cfg_data;
			// check the outgoing byte before anything this edge adds
			if (out_valid && out_ready) begin
				if (reply_bytes.size() == 0) begin
					fails++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: unexpected reply byte %h last %b",
							out_item.tx_byte, out_item.last_byte);
				end else begin
					want = reply_bytes.pop_front();
					if (out_item.tx_byte !== want.tx_byte ||
							out_item.last_byte !== want.last_byte) begin
						fails++;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: byte exp %h got %h, last exp %b got %b",
								want.tx_byte, out_item.tx_byte,
								want.last_byte, out_item.last_byte);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_item.command == scfr_pkg::KIND_SAMPLE)
					take_reading(in_item);
				else
					take_byte(in_item.rx_byte);
			end
			pending <= reply_bytes.size();
		end
	end

endmodule

[verif/tb_serial_command_frame_responder.sv]
// stimulus and verdict for the serial command frame responder
module tb_serial_command_frame_responder;

	localparam int RANDOM_ITEMS = 300;
	localparam int HOLD_CYCLES  = 300;
	// no legal run goes this long without a handshake, the output hold included
	localparam int STALL_LIMIT  = 4000;

	typedef enum int {
		FLT_NONE,
		FLT_CHK1,
		FLT_CHK2,
		FLT_SHORT,
		FLT_ID,
		FLT_HDR
	} frame_fault_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	scfr_pkg::in_item_t   in_item;
	logic                 out_valid;
	logic                 out_ready;
	scfr_pkg::out_item_t  out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [7:0]           cfg_data;

	int         fails;
	int         pending;
	int         replies;

	// stimulus bookkeeping
	logic [7:0] cur_id;
	bit         idle_on;
	int         hold_reqs;
	int         holds_done;
	int         items_sent;
	int         ids_used;
	int         stall_cycles;

	serial_command_frame_responder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	scfr_reply_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending),
		.replies   (replies)
	);

	// free running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: ends the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d bytes still owed",
				stall_cycles, pending);
			$display("FAIL serial_command_frame_responder");
			$finish;
		end
	end

	// reply receiver: random back pressure, plus a long hold on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_reqs) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= !idle_on || ($urandom_range(99) >= 13);
		end
	end

	// one item on the input channel, with an occasional gap in front
	task automatic send_item(input scfr_pkg::in_item_t it);
		if (idle_on && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// serial byte; the sample fields ride along as noise
	task automatic send_byte(input logic [7:0] b);
		scfr_pkg::in_item_t it;
		it.command   = scfr_pkg::KIND_BYTE;
		it.rx_byte   = b;
		it.red       = 16'($urandom);
		it.green     = 16'($urandom);
		it.blue      = 16'($urandom);
		it.proximity = 8'($urandom);
		send_item(it);
	endtask

	task automatic send_sample(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b, input logic [7:0] p);
		scfr_pkg::in_item_t it;
		it.command   = scfr_pkg::KIND_SAMPLE;
		it.rx_byte   = 8'($urandom);
		it.red       = r;
		it.green     = g;
		it.blue      = b;
		it.proximity = p;
		send_item(it);
	endtask

	// random sample, sometimes with red equal to green
	task automatic random_sample();
		logic [15:0] r;
		logic [15:0] g;
		r = 16'($urandom);
		g = ($urandom_range(9) == 0) ? r : 16'($urandom);
		send_sample(r, g, 16'($urandom), 8'($urandom));
	endtask

	// request frame, optionally broken in one way
	task automatic send_frame(input logic [7:0] cmd, input logic [7:0] data,
			input logic [7:0] size, input frame_fault_t fault);
		logic [7:0] fb [$];
		logic [7:0] id;
		logic [7:0] sz;
		logic [7:0] s;
		logic [7:0] c1;
		logic [7:0] c2;
		id = cur_id;
		sz = size;
		if (fault == FLT_ID)
			id = cur_id ^ (8'd1 << $urandom_range(7, 0));
		if (fault == FLT_SHORT)
			sz = 8'($urandom_range(6, 0));
		s = scfr_pkg::HDR_BYTE + scfr_pkg::HDR_BYTE + sz + id + cmd;
		if (sz > scfr_pkg::MIN_SIZE)
			s = s + data;
		c1 = s & scfr_pkg::CHECK_MASK;
		c2 = ~c1 & scfr_pkg::CHECK_MASK;
		if (fault == FLT_CHK1)
			c1 = c1 ^ (8'd1 << $urandom_range(7, 0));
		if (fault == FLT_CHK2)
			c2 = c2 ^ (8'd1 << $urandom_range(7, 0));
		fb = '{scfr_pkg::HDR_BYTE, scfr_pkg::HDR_BYTE, sz, id, cmd, c1, c2};
		// second header byte that is not a header
		if (fault == FLT_HDR)
			fb[1] = 8'($urandom_range(254, 0));
		if (sz > scfr_pkg::MIN_SIZE)
			fb.push_back(data);
		foreach (fb[j]) begin
			// a sample may land in the middle of a frame
			if ($urandom_range(99) < 4)
				random_sample();
			send_byte(fb[j]);
		end
	endtask

	// random request code, now and then one the block does not know
	function automatic logic [7:0] pick_cmd();
		case ($urandom_range(9, 0))
			0: pick_cmd = scfr_pkg::CMD_ALL;
			1: pick_cmd = scfr_pkg::CMD_RED;
			2: pick_cmd = scfr_pkg::CMD_GREEN;
			3: pick_cmd = scfr_pkg::CMD_BLUE;
			4: pick_cmd = scfr_pkg::CMD_PROX;
			5: pick_cmd = scfr_pkg::CMD_COLOR;
			6: pick_cmd = scfr_pkg::CMD_SET_LED;
			7: pick_cmd = scfr_pkg::CMD_SET_THRES;
			8: pick_cmd = scfr_pkg::CMD_COLOR;
			default: pick_cmd = $urandom_range(1) ? 8'($urandom_range(7, 6))
				: 8'($urandom_range(255, 10));
		endcase
	endfunction

	task automatic random_frame(input frame_fault_t fault);
		logic [7:0] cmd;
		logic [7:0] data;
		logic [7:0] size;
		int         r;
		cmd = pick_cmd();
		r = $urandom_range(99);
		if (r < 45)
			size = scfr_pkg::MIN_SIZE;
		else if (r < 88)
			size = scfr_pkg::MIN_SIZE + 8'd1;
		else
			size = 8'($urandom_range(255, 9));
		case ($urandom_range(5))
			0: data = 8'h00;
			1: data = 8'hFF;
			default: data = 8'($urandom);
		endcase
		send_frame(cmd, data, size, fault);
	endtask

	// mostly good frames, mixed with broken ones, samples and loose bytes
	task automatic random_traffic(input int count);
		int           stop;
		int           r;
		frame_fault_t fault;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			if (r < 70) begin
				random_frame(FLT_NONE);
			end else if (r < 84) begin
				fault = frame_fault_t'($urandom_range(FLT_HDR, FLT_CHK1));
				random_frame(fault);
			end else if (r < 93) begin
				random_sample();
			end else begin
				send_byte($urandom_range(1) ? scfr_pkg::HDR_BYTE : 8'($urandom));
			end
		end
	endtask

	// stop sending and let every owed reply byte come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_id(input logic [7:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_id = v;
		ids_used++;
	endtask

	// main sequence
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_data  = 8'h00;
		cur_id    = 8'h00;
		idle_on   = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every request, each way a frame gets dropped
		write_id(8'd0);
		send_sample(16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF);
		send_frame(scfr_pkg::CMD_ALL, 8'h00, 8'd7, FLT_NONE);
		send_frame(scfr_pkg::CMD_RED, 8'hFF, 8'd8, FLT_NONE);
		send_frame(scfr_pkg::CMD_GREEN, 8'h00, 8'd7, FLT_NONE);
		send_frame(scfr_pkg::CMD_BLUE, 8'h5A, 8'd8, FLT_NONE);
		send_frame(scfr_pkg::CMD_PROX, 8'h00, 8'd7, FLT_NONE);
		send_frame(scfr_pkg::CMD_COLOR, 8'h00, 8'd7, FLT_NONE);
		send_frame(scfr_pkg::CMD_SET_LED, 8'h00, 8'd7, FLT_NONE);
		// threshold 0, so the next sample classifies even at proximity 0
		send_frame(scfr_pkg::CMD_SET_THRES, 8'h00, 8'd8, FLT_NONE);
		send_sample(16'h0000, 16'hFFFF, 16'h0000, 8'h00);
		send_frame(scfr_pkg::CMD_COLOR, 8'h00, 8'd7, FLT_NONE);
		// threshold change does not reclassify the stored sample
		send_frame(scfr_pkg::CMD_SET_THRES, 8'hFF, 8'd8, FLT_NONE);
		send_frame(scfr_pkg::CMD_COLOR, 8'h00, 8'd7, FLT_NONE);
		send_sample(16'h8000, 16'h7FFF, 16'h1234, 8'hFE);
		send_frame(scfr_pkg::CMD_ALL, 8'h00, 8'd7, FLT_NONE);
		send_frame(8'h06, 8'h00, 8'd7, FLT_NONE);
		send_frame(scfr_pkg::CMD_RED, 8'h00, 8'd7, FLT_SHORT);
		send_frame(scfr_pkg::CMD_RED, 8'h00, 8'd7, FLT_ID);
		send_frame(scfr_pkg::CMD_RED, 8'h00, 8'd7, FLT_HDR);
		send_frame(scfr_pkg::CMD_RED, 8'h00, 8'd8, FLT_CHK1);
		send_frame(scfr_pkg::CMD_RED, 8'h00, 8'd7, FLT_CHK2);
		// long frame, the next frame starts right after its data byte
		send_frame(scfr_pkg::CMD_BLUE, 8'h33, 8'd255, FLT_NONE);
		send_frame(scfr_pkg::CMD_SET_THRES, 8'h00, 8'd7, FLT_NONE);
		drain();

		// phase with id 253, output held while the sender keeps pushing
		write_id(8'd253);
		random_traffic(RANDOM_ITEMS / 8);
		hold_reqs <= hold_reqs + 1;
		repeat (4) send_frame(scfr_pkg::CMD_ALL, 8'h00, 8'd7, FLT_NONE);
		random_traffic(RANDOM_ITEMS / 8);
		drain();

		// phase with a random id and no idling on either side
		write_id(8'($urandom_range(252, 1)));
		idle_on = 1'b0;
		random_traffic(RANDOM_ITEMS / 4);
		drain();
		idle_on = 1'b1;

		// phase with another random id
		write_id(8'($urandom_range(253, 0)));
		random_traffic(RANDOM_ITEMS / 4);
		drain();

		// back to id 0
		write_id(8'd0);
		random_traffic(RANDOM_ITEMS / 4);
		drain();
		repeat (8) @(posedge clk);

		$display("covered %0d input items under %0d id settings, %0d replies checked",
			items_sent, ids_used, replies);
		$display("with broken frames, samples inside frames and a %0d cycle output hold",
			HOLD_CYCLES);
		if (fails == 0 && pending == 0) begin
			$display("PASS serial_command_frame_responder");
		end else begin
			$display("errors %0d, reply bytes never seen %0d", fails, pending);
			$display("FAIL serial_command_frame_responder");
		end
		$finish;
	end

endmodule
